### src/ttc_pkg.sv
// Package for the tilt-to-cursor-and-tone block: payload types, sequencer
// states, the step-control struct and the fixed field widths.
// No dependencies.
package ttc_pkg;

  // Offset magnitudes: |accel - ref| is at most 65535.
  localparam int MAG_W  = 16;
  // Squares of a magnitude; their sum takes the wider radicand below.
  localparam int SQ_W   = 2 * MAG_W;
  // Root of the sum of squares, and its radicand padded to whole bit pairs.
  localparam int ROOT_W = MAG_W + 1;
  localparam int RAD_W  = 2 * ROOT_W;
  // Shift-and-add multiply steps, one multiplier bit per cycle.
  localparam int MUL_STEPS = MAG_W;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
  } ttc_in_t;

  typedef struct packed {
    logic [6:0]  horiz_pos;
    logic [6:0]  vert_pos;
    logic [12:0] tone_period;
  } ttc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } ttc_state_t;

  // Control of a serial unit: load takes new operands, step advances one digit.
  typedef struct packed {
    logic load;
    logic step;
  } ttc_step_ctl_t;

endpackage

### src/tilt_to_cursor_and_tone_core.sv
// Tilt to cursor and tone. The first request after reset is kept as the level
// reference and gives no result; every later request gives one result with a
// cursor position and a tone period. Each request with a result passes from
// acceptance through shift-and-add multiplication, a load step and the two
// constant dividers at one quotient bit per cycle (the square root runs
// alongside them) to the write of the result, which waits until the output
// register can take it. The reference request is taken while idle and starts
// no sequence. The block takes a new request while a finished result still
// waits in the output register.
module tilt_to_cursor_and_tone_core #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 128,
  parameter int MARGIN_RADIUS = 20,
  parameter int FULL_SCALE    = 8000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  ttc_pkg::ttc_in_t  sample,
  output logic              result_valid,
  input  logic              result_ready,
  output ttc_pkg::ttc_out_t result
);
  import ttc_pkg::*;

  // Width of the screen sizes, and of the scaled offsets |d| * size that the
  // dividers take apart one bit per cycle.
  localparam int SIZE_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int SZ_W     = $clog2(SIZE_MAX + 1);
  localparam int DVD_W    = MAG_W + SZ_W;
  localparam int POS_W    = DVD_W + 2;
  localparam int CNT_W    = $clog2(DVD_W);

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);
  localparam logic [CNT_W-1:0] SQRT_N   = CNT_W'(ROOT_W);

  localparam logic signed [POS_W-1:0] HALF_W = POS_W'(SCREEN_WIDTH / 2);
  localparam logic signed [POS_W-1:0] HALF_H = POS_W'(SCREEN_HEIGHT / 2);
  localparam logic signed [POS_W-1:0] HI_W   = POS_W'(SCREEN_WIDTH - MARGIN_RADIUS);
  localparam logic signed [POS_W-1:0] HI_H   = POS_W'(SCREEN_HEIGHT - MARGIN_RADIUS);
  localparam logic signed [POS_W-1:0] LO_POS = POS_W'(MARGIN_RADIUS);
  localparam logic [ROOT_W:0]         FS_C   = (ROOT_W + 1)'(FULL_SCALE);

  // Sequencer.
  ttc_state_t       state;
  ttc_state_t       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // Level reference.
  logic                    ref_captured;
  logic signed [15:0]      level_ref_x;
  logic signed [15:0]      level_ref_y;

  // Offsets as sign and magnitude; X drives the vertical position.
  logic                    neg_x;
  logic                    neg_y;
  logic signed [MAG_W:0]   dx;
  logic signed [MAG_W:0]   dy;
  logic [MAG_W:0]          abs_x;
  logic [MAG_W:0]          abs_y;

  // Shift-and-add multipliers: the multiplier bits shift out at the bottom
  // while the multiplicands shift up, one bit of weight per cycle.
  logic [MAG_W-1:0]        mul_x;
  logic [MAG_W-1:0]        mul_y;
  logic [SQ_W-1:0]         sh_x;
  logic [SQ_W-1:0]         sh_y;
  logic [DVD_W-1:0]        sh_w;
  logic [DVD_W-1:0]        sh_h;
  logic [SQ_W-1:0]         sq_x;
  logic [SQ_W-1:0]         sq_y;
  logic [DVD_W-1:0]        scl_x;
  logic [DVD_W-1:0]        scl_y;

  // Serial units.
  ttc_step_ctl_t           div_ctl;
  ttc_step_ctl_t           sqrt_ctl;
  logic [DVD_W-1:0]        quot_x;
  logic [DVD_W-1:0]        quot_y;
  logic [RAD_W-1:0]        radicand;
  logic [ROOT_W:0]         mag;

  // Final positions and tone.
  logic signed [POS_W-1:0] q_x;
  logic signed [POS_W-1:0] q_y;
  logic signed [POS_W-1:0] h_raw;
  logic signed [POS_W-1:0] v_raw;
  logic signed [POS_W-1:0] h_pos;
  logic signed [POS_W-1:0] v_pos;
  logic [ROOT_W:0]         period_diff;
  ttc_out_t                res_calc;
  logic                    res_write;

  assign sample_ready = (state == ST_IDLE);

  assign dx    = (MAG_W + 1)'(sample.accel_x) - (MAG_W + 1)'(level_ref_x);
  assign dy    = (MAG_W + 1)'(sample.accel_y) - (MAG_W + 1)'(level_ref_y);
  assign abs_x = dx[MAG_W] ? -dx : dx;
  assign abs_y = dy[MAG_W] ? -dy : dy;

  // Sequencer: next state, step counter and unit control.
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    div_ctl       = '0;
    sqrt_ctl      = '0;
    res_write     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (sample_valid && ref_captured) begin
          state_next = ST_MUL;
          cnt_next   = '0;
        end
      end
      ST_MUL: begin
        cnt_next = cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        div_ctl.load  = 1'b1;
        sqrt_ctl.load = 1'b1;
        state_next    = ST_DIV;
        cnt_next      = '0;
      end
      ST_DIV: begin
        div_ctl.step  = 1'b1;
        sqrt_ctl.step = (cnt < SQRT_N);
        cnt_next      = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait until the output register is free or being emptied.
        if (!result_valid || result_ready) begin
          res_write  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      ref_captured <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == ST_IDLE && sample_valid && !ref_captured) begin
        ref_captured <= 1'b1;
      end
    end
  end

  // Reference capture and the multiply datapath.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample_valid) begin
      if (!ref_captured) begin
        level_ref_x <= sample.accel_x;
        level_ref_y <= sample.accel_y;
      end else begin
        neg_x <= dx[MAG_W];
        neg_y <= dy[MAG_W];
        mul_x <= abs_x[MAG_W-1:0];
        mul_y <= abs_y[MAG_W-1:0];
        sh_x  <= SQ_W'(abs_x[MAG_W-1:0]);
        sh_y  <= SQ_W'(abs_y[MAG_W-1:0]);
        sh_w  <= DVD_W'(SCREEN_WIDTH);
        sh_h  <= DVD_W'(SCREEN_HEIGHT);
        sq_x  <= '0;
        sq_y  <= '0;
        scl_x <= '0;
        scl_y <= '0;
      end
    end else if (state == ST_MUL) begin
      mul_x <= mul_x >> 1;
      mul_y <= mul_y >> 1;
      sh_x  <= sh_x << 1;
      sh_y  <= sh_y << 1;
      sh_w  <= sh_w << 1;
      sh_h  <= sh_h << 1;
      if (mul_x[0]) begin
        sq_x  <= sq_x + sh_x;
        scl_x <= scl_x + sh_w;
      end
      if (mul_y[0]) begin
        sq_y  <= sq_y + sh_y;
        scl_y <= scl_y + sh_h;
      end
    end
  end

  assign radicand = RAD_W'(sq_x) + RAD_W'(sq_y);

  ttc_serial_div #(
    .DVD_W   (DVD_W),
    .DIVISOR (FULL_SCALE)
  ) u_div_x (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (scl_x),
    .quotient (quot_x)
  );

  ttc_serial_div #(
    .DVD_W   (DVD_W),
    .DIVISOR (FULL_SCALE)
  ) u_div_y (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (scl_y),
    .quotient (quot_y)
  );

  ttc_serial_sqrt u_sqrt (
    .clk       (clk),
    .ctl       (sqrt_ctl),
    .radicand  (radicand),
    .root_ceil (mag)
  );

  // The quotients are magnitudes, so applying the sign afterwards gives
  // division that truncates toward zero. Tilt in Y moves the cursor with the
  // offset, tilt in X against it. The upper bound is applied before the lower.
  always_comb begin
    q_x   = $signed({2'b00, quot_x});
    q_y   = $signed({2'b00, quot_y});
    h_raw = neg_y ? (HALF_H - q_y) : (HALF_H + q_y);
    v_raw = neg_x ? (HALF_W + q_x) : (HALF_W - q_x);
    h_pos = (h_raw > HI_H) ? HI_H : h_raw;
    h_pos = (h_pos < LO_POS) ? LO_POS : h_pos;
    v_pos = (v_raw > HI_W) ? HI_W : v_raw;
    v_pos = (v_pos < LO_POS) ? LO_POS : v_pos;
    period_diff = FS_C - mag;
    res_calc.horiz_pos   = h_pos[6:0];
    res_calc.vert_pos    = v_pos[6:0];
    res_calc.tone_period = (mag >= FS_C) ? 13'd0 : period_diff[12:0];
  end

  // Output register: parts the result side from the request side.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_write) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_write) begin
      result <= res_calc;
    end
  end

  // No result can exist before a level reference has been taken.
  a_result_needs_ref: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ref_captured)
    else $error("result present without a level reference");

  // A new result is only ever written out of the final sequencer step.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result appeared outside the write step");

  // The reference request produces no work for the sequencer.
  a_ref_no_work: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready && !ref_captured) |=> (ref_captured && state == ST_IDLE))
    else $error("reference request did not return to idle");

  // The serial units always start their digit steps from a fresh load.
  a_load_then_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |=> (state == ST_DIV && cnt == '0))
    else $error("divide phase did not start at step zero");

endmodule

### src/ttc_serial_div.sv
// Bit-serial restoring divider by a constant divisor, one quotient bit per step.
// Depends on ttc_pkg for the step-control struct.
module ttc_serial_div #(
  parameter int DVD_W   = 24,
  parameter int DIVISOR = 8000
) (
  input  logic                   clk,
  input  ttc_pkg::ttc_step_ctl_t ctl,
  input  logic [DVD_W-1:0]       dividend,
  output logic [DVD_W-1:0]       quotient
);
  import ttc_pkg::*;

  localparam int REM_W = $clog2(DIVISOR + 1);
  localparam logic [REM_W:0] DIV_C = (REM_W + 1)'(DIVISOR);

  logic [REM_W-1:0] rem;
  logic [DVD_W-1:0] dvd;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;

  // The dividend shifts out at the top while quotient bits shift in below,
  // so after DVD_W steps the register holds the quotient.
  assign trial = {rem, dvd[DVD_W-1]};
  assign ge    = (trial >= DIV_C);
  assign diff  = trial - DIV_C;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= '0;
      dvd <= dividend;
    end else if (ctl.step) begin
      rem <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      dvd <= {dvd[DVD_W-2:0], ge};
    end
  end

  assign quotient = dvd;

endmodule

### src/ttc_serial_sqrt.sv
// Digit-serial integer square root, one bit pair of the radicand per step,
// giving the root rounded up. Depends on ttc_pkg for widths and control.
module ttc_serial_sqrt (
  input  logic                       clk,
  input  ttc_pkg::ttc_step_ctl_t     ctl,
  input  logic [ttc_pkg::RAD_W-1:0]  radicand,
  output logic [ttc_pkg::ROOT_W:0]   root_ceil
);
  import ttc_pkg::*;

  localparam int REM_W = ROOT_W + 1;
  localparam int WRK_W = REM_W + 2;

  logic [RAD_W-1:0]  rad;
  logic [ROOT_W-1:0] root;
  logic [REM_W-1:0]  rem;
  logic [WRK_W-1:0]  shifted;
  logic [WRK_W-1:0]  trial;
  logic [WRK_W-1:0]  diff;
  logic              ge;

  // Bring down the next bit pair and try the next root bit. The partial
  // remainder never exceeds twice the partial root, so REM_W bits hold it.
  assign shifted = {rem, rad[RAD_W-1:RAD_W-2]};
  assign trial   = {1'b0, root, 2'b01};
  assign ge      = (shifted >= trial);
  assign diff    = shifted - trial;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rad  <= radicand;
      root <= '0;
      rem  <= '0;
    end else if (ctl.step) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      root <= {root[ROOT_W-2:0], ge};
      rem  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    end
  end

  // A nonzero remainder means the radicand was not a perfect square.
  assign root_ceil = {1'b0, root} + (ROOT_W + 1)'(rem != '0);

endmodule

### sim/ttc_checker.sv
`timescale 1ns / 100ps
// Result checker for tilt_to_cursor_and_tone_core: watches both channels,
// predicts each cursor and tone result and compares it. Depends on ttc_pkg.
module ttc_checker
  import ttc_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 128,
  parameter int MARGIN_RADIUS = 20,
  parameter int FULL_SCALE    = 8000
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     sample_valid,
  input  logic     sample_ready,
  input  ttc_in_t  sample,
  input  logic     result_valid,
  input  logic     result_ready,
  input  ttc_out_t result,
  output int       mismatches,
  output int       outstanding
);

  logic signed [15:0] level_x;
  logic signed [15:0] level_y;
  logic               level_taken;
  ttc_out_t           pending_results[$];
  ttc_out_t           want;

  // Floor of the square root, two radicand bits per iteration.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Upper bound first, then lower bound.
  function automatic longint clamp_to_margin(longint p, longint span);
    if (p > span - MARGIN_RADIUS) p = span - MARGIN_RADIUS;
    if (p < MARGIN_RADIUS) p = MARGIN_RADIUS;
    return p;
  endfunction

  function automatic ttc_out_t cursor_and_tone(longint dx, longint dy);
    longint          h;
    longint          v;
    longint          period;
    longint unsigned sq;
    longint unsigned mag;
    ttc_out_t        r;
    // Signed division truncates toward zero, as the block must.
    h      = clamp_to_margin(SCREEN_HEIGHT / 2 + (dy * SCREEN_HEIGHT) / FULL_SCALE,
                             SCREEN_HEIGHT);
    v      = clamp_to_margin(SCREEN_WIDTH / 2 - (dx * SCREEN_WIDTH) / FULL_SCALE,
                             SCREEN_WIDTH);
    sq     = longint'(dx * dx) + longint'(dy * dy);
    mag    = floor_root(sq);
    if (mag * mag != sq) mag = mag + 1;
    period = longint'(FULL_SCALE) - longint'(mag);
    if (period < 0) period = 0;
    r.horiz_pos   = h[6:0];
    r.vert_pos    = v[6:0];
    r.tone_period = period[12:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      level_taken = 1'b0;
      level_x     = '0;
      level_y     = '0;
      pending_results.delete();
    end else begin
      // Results come many cycles after their request, so check before pushing.
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ttc_checker: unexpected result h=%0d v=%0d tone=%0d", $time,
                   result.horiz_pos, result.vert_pos, result.tone_period);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (result.horiz_pos !== want.horiz_pos) begin
            $display("%0t ttc_checker: horiz_pos expected %0d got %0d", $time,
                     want.horiz_pos, result.horiz_pos);
            mismatches++;
          end
          if (result.vert_pos !== want.vert_pos) begin
            $display("%0t ttc_checker: vert_pos expected %0d got %0d", $time,
                     want.vert_pos, result.vert_pos);
            mismatches++;
          end
          if (result.tone_period !== want.tone_period) begin
            $display("%0t ttc_checker: tone_period expected %0d got %0d", $time,
                     want.tone_period, result.tone_period);
            mismatches++;
          end
        end
      end
      if (sample_valid && sample_ready) begin
        if (!level_taken) begin
          level_x     = sample.accel_x;
          level_y     = sample.accel_y;
          level_taken = 1'b1;
        end else begin
          pending_results.push_back(cursor_and_tone(
              longint'($signed(sample.accel_x)) - longint'(level_x),
              longint'($signed(sample.accel_y)) - longint'(level_y)));
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Top of the testbench for tilt_to_cursor_and_tone_core: clock, reset,
// request stimulus and result backpressure. Depends on ttc_pkg and ttc_checker.
module tb;
  import ttc_pkg::*;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 128;
  localparam int MARGIN_RADIUS = 20;
  localparam int FULL_SCALE    = 8000;

  // About 850 requests in all; the first few are the directed ones.
  localparam int REQUEST_COUNT = 850;
  // A result takes a full pass of the sequencer, the sender leaves gaps between
  // bursts and the receiver holds off in its hold mode. Any stretch far beyond
  // that with no handshake at all means the block has hung.
  localparam int STALL_LIMIT   = 2000;
  // Cycles to keep watching after the last expected result, so that a
  // spurious extra result still gets caught.
  localparam int DRAIN_CYCLES  = 100;

  // Receiver behavior, switched from time to time.
  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_SPARSE,
    RX_HOLD
  } rx_mode_t;

  logic     clk;
  logic     rst;
  logic     sample_valid;
  logic     sample_ready;
  ttc_in_t  sample;
  logic     result_valid;
  logic     result_ready;
  ttc_out_t result;
  int       mismatches;
  int       outstanding;

  // The level reference that the first request sets.
  int       level_x;
  int       level_y;

  tilt_to_cursor_and_tone_core #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .MARGIN_RADIUS(MARGIN_RADIUS),
    .FULL_SCALE   (FULL_SCALE)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  ttc_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .MARGIN_RADIUS(MARGIN_RADIUS),
    .FULL_SCALE   (FULL_SCALE)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A sample at the given offset from the level reference. The reading
  // saturates at the 16-bit limits, which is also how the directed part
  // reaches the extreme readings.
  function automatic ttc_in_t from_offset(int dx, int dy);
    int       x;
    int       y;
    ttc_in_t  s;
    x = level_x + dx;
    y = level_y + dy;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    s.accel_x = x[15:0];
    s.accel_y = y[15:0];
    return s;
  endfunction

  // Most random requests are offsets from level; nearer ones keep the
  // cursor inside the margins with a nonzero tone. The rest are raw
  // 16-bit readings that toggle every bit and mostly land clamped and silent.
  function automatic ttc_in_t random_sample();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) begin
      return from_offset(int'($urandom_range(6000)) - 3000,
                         int'($urandom_range(6000)) - 3000);
    end else if (pick < 7) begin
      return from_offset(int'($urandom_range(18000)) - 9000,
                         int'($urandom_range(18000)) - 9000);
    end
    return ttc_in_t'($urandom);
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_sample(input ttc_in_t s);
    @(negedge clk);
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
  endtask

  // Receiver: stretches of constant readiness alternate with random stalls,
  // sparse acceptance and long holds, so that a finished result waits in the
  // output register while the block goes on with the next request.
  initial begin
    rx_mode_t mode;
    int       span;
    result_ready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(3));
      span = $urandom_range(20, 150);
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (mode)
          RX_ALWAYS: begin
            result_ready <= 1'b1;
          end
          RX_RANDOM: begin
            result_ready <= 1'($urandom_range(1));
          end
          RX_SPARSE: begin
            result_ready <= ($urandom_range(7) == 0);
          end
          default: begin
            result_ready <= (i % 80 == 79);
          end
        endcase
      end
    end
  end

  // Watchdog: ends the run once nothing has moved on either channel for too
  // long. Reset cycles count as progress.
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    ttc_in_t directed[$];
    ttc_in_t s;
    int      burst_left;
    int      gap;

    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The reference sits a little off zero so that offsets of both signs
    // reach far into the range.
    level_x = int'($urandom_range(2000)) - 1000;
    level_y = int'($urandom_range(2000)) - 1000;

    // The first request becomes the level reference and must give nothing.
    directed.push_back(from_offset(0, 0));
    // Back at level: centered cursor and the full tone period.
    directed.push_back(from_offset(0, 0));
    // Extreme readings in all four corners.
    directed.push_back(from_offset(70000, 70000));
    directed.push_back(from_offset(-70000, -70000));
    directed.push_back(from_offset(-70000, 70000));
    directed.push_back(from_offset(70000, -70000));
    // Magnitude exactly at full scale, just below it and just above it.
    directed.push_back(from_offset(FULL_SCALE, 0));
    directed.push_back(from_offset(FULL_SCALE - 1, 0));
    directed.push_back(from_offset(0, -FULL_SCALE - 1));
    // A perfect square magnitude, its neighbor that rounds up, and a tiny one.
    directed.push_back(from_offset(3000, 4000));
    directed.push_back(from_offset(3000, 4001));
    directed.push_back(from_offset(1, 1));
    // Offsets near one step: negative ones truncate toward zero, not down.
    directed.push_back(from_offset(0, -62));
    directed.push_back(from_offset(0, -63));
    directed.push_back(from_offset(62, 0));
    directed.push_back(from_offset(-63, 0));
    // Both sides of the margin clamps on either coordinate.
    directed.push_back(from_offset(0, 2750));
    directed.push_back(from_offset(0, 2749));
    directed.push_back(from_offset(0, -2750));
    directed.push_back(from_offset(-2749, 0));
    directed.push_back(from_offset(2750, -2750));
    directed.push_back(from_offset(-2812, 2812));

    // Requests go out in bursts; between bursts the valid drops for a while
    // and the data lines carry junk that the block must ignore. About a
    // quarter of the bursts run straight into the next one with no gap.
    burst_left = 0;
    for (int i = 0; i < REQUEST_COUNT; i++) begin
      if (i < directed.size()) begin
        s = directed[i];
      end else begin
        s = random_sample();
      end
      send_sample(s);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          @(negedge clk);
          sample_valid <= 1'b0;
          sample       <= ttc_in_t'($urandom);
          repeat (gap - 1) @(negedge clk);
        end
      end else begin
        burst_left--;
      end
    end

    @(negedge clk);
    sample_valid <= 1'b0;
    // Wait for every predicted result, then watch a little longer.
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
